[rtl/mnr_pkg.sv]
// Shared definitions for the five-port mesh router with LBDR routing.
// Holds widths, port, mode and kind codes, the FIFO slot type and the route function.
// No dependencies.
`default_nettype none

package mnr_pkg;

	localparam int MESH_SIZE   = 4;
	localparam int FIFO_DEPTH  = 3;
	localparam int MAX_CREDITS = 3;

	localparam int NPORTS     = 5;
	localparam int NMESH      = 4;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int PORT_W     = 3;
	localparam int MODE_W     = 2;
	localparam int KIND_W     = 2;
	localparam int RBITS_W    = 8;
	localparam int CONN_W     = 4;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CRED_W     = $clog2(MAX_CREDITS + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Port codes, also used as route requests; REQ_IDLE means no route held.
	localparam logic [PORT_W-1:0] PORT_N    = 3'd0;
	localparam logic [PORT_W-1:0] PORT_E    = 3'd1;
	localparam logic [PORT_W-1:0] PORT_WEST = 3'd2;
	localparam logic [PORT_W-1:0] PORT_S    = 3'd3;
	localparam logic [PORT_W-1:0] PORT_L    = 3'd4;
	localparam logic [PORT_W-1:0] REQ_IDLE  = 3'd5;

	localparam logic [MODE_W-1:0] MODE_FLIT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CREDIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BODY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TAIL   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTING  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONNECT  = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] dest;
	} slot_t;

	// Row of a node address: compare against each row boundary, no divider.
	function automatic logic [ADDR_W-1:0] addr_row(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] row;
		row = '0;
		for (int r = 1; r < (1 << ADDR_W); r++) begin
			if ((r * MESH_SIZE < (1 << ADDR_W)) && (int'(a) >= r * MESH_SIZE))
				row = ADDR_W'(r);
		end
		return row;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_col(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(int'(addr_row(a)) * MESH_SIZE);
		return a - base;
	endfunction

	// LBDR output selection in fixed priority N, E, W, S, then local.
	function automatic logic [PORT_W-1:0] lbdr_route(
		input logic [ADDR_W-1:0]  dest,
		input logic [ADDR_W-1:0]  own,
		input logic [RBITS_W-1:0] r,
		input logic [CONN_W-1:0]  c,
		input logic [NPORTS-1:0]  g
	);
		logic [ADDR_W-1:0] dx, dy, cx, cy;
		logic n, e, w, s;
		logic [PORT_W-1:0] res;
		dx = addr_col(dest);
		dy = addr_row(dest);
		cx = addr_col(own);
		cy = addr_row(own);
		n = dy < cy;
		e = cx < dx;
		w = dx < cx;
		s = cy < dy;
		res = REQ_IDLE;
		if (((n && !e && !w) || (n && e && r[0]) || (n && w && r[1])) && c[0] && !g[PORT_N])
			res = PORT_N;
		else if (((e && !n && !s) || (e && n && r[2]) || (e && s && r[3]))
				&& c[1] && !g[PORT_E])
			res = PORT_E;
		else if (((w && !n && !s) || (w && n && r[4]) || (w && s && r[5]))
				&& c[2] && !g[PORT_WEST])
			res = PORT_WEST;
		else if (((s && !e && !w) || (s && e && r[6]) || (s && w && r[7]))
				&& c[3] && !g[PORT_S])
			res = PORT_S;
		else if (!n && !e && !w && !s && !g[PORT_L])
			res = PORT_L;
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/mnr_if.sv]
// Valid/ready channel interfaces for the mesh router: event items in, results out.
// Depends on mnr_pkg for field widths.
`default_nettype none

interface mnr_in_if import mnr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [PORT_W-1:0]   port;
	logic [DATA_W-1:0]   flit_data;
	logic [KIND_W-1:0]   flit_kind;
	logic [ADDR_W-1:0]   dest_address;

	modport source (output valid, mode, port, flit_data, flit_kind, dest_address,
		input ready);
	modport sink (input valid, mode, port, flit_data, flit_kind, dest_address,
		output ready);
endinterface

interface mnr_out_if import mnr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                sent;
	logic [PORT_W-1:0]   out_port;
	logic [DATA_W-1:0]   flit_out;
	logic [PORT_W-1:0]   credit_port;
	logic                dropped;

	modport source (output valid, sent, out_port, flit_out, credit_port, dropped,
		input ready);
	modport sink (input valid, sent, out_port, flit_out, credit_port, dropped,
		output ready);
endinterface

`default_nettype wire

[rtl/mesh_noc_router_lbdr.sv]
// Five-port wormhole mesh router with LBDR routing and credit flow control.
// Depends on mnr_pkg and on the channel interfaces in mnr_if.sv.
//
//   Channel  | Direction | Handshake    | Carries
//   ---------+-----------+--------------+----------------------------------------------
//   items    | in        | valid/ready  | mode, port, flit_data, flit_kind, dest_address
//   results  | out       | valid/ready  | sent, out_port, flit_out, credit_port, dropped
//   cfg      | in        | cfg_wr_en    | cfg_index, cfg_data (no read-back)
//
// One item is accepted per clock unless the result register stalls; its one result goes
// from the input register, where the routing logic works on the item, to the result register.
// The rate is set by the single state-update pass.
// A stalled result register holds the input register, which in turn drops items.ready.
// Reset empties all FIFOs, clears grants and credits and makes every input idle; the FIFO
// slots themselves are not cleared, as only written slots are ever read.
`default_nettype none

module mesh_noc_router_lbdr import mnr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mnr_in_if.sink                items,
	mnr_out_if.source             results,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [ADDR_W-1:0]  own_addr_q;
	logic [RBITS_W-1:0] routing_q;
	logic [CONN_W-1:0]  connect_q;

	// Input register stage.
	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [PORT_W-1:0] port_s1;
	slot_t             slot_s1;

	// Router state. Each FIFO keeps its oldest flit in entry 0 and shifts on a pop.
	slot_t             fifo_q   [NPORTS][FIFO_DEPTH];
	logic [CNT_W-1:0]  count_q  [NPORTS];
	logic [PORT_W-1:0] req_q    [NPORTS];
	logic [NPORTS-1:0] grant_q;
	logic [CRED_W-1:0] cred_q   [NMESH];

	// Next-state values from the single update pass.
	logic [CNT_W-1:0]  count_n  [NPORTS];
	logic [PORT_W-1:0] req_n    [NPORTS];
	logic [NPORTS-1:0] grant_n;
	logic [CRED_W-1:0] cred_n   [NMESH];
	logic [NPORTS-1:0] push;
	logic [NPORTS-1:0] pop;

	// Result of the current item.
	logic              sent_n;
	logic [PORT_W-1:0] out_port_n;
	logic [DATA_W-1:0] flit_out_n;
	logic [PORT_W-1:0] credit_port_n;
	logic              dropped_n;

	// Result register.
	logic              res_valid_q;
	logic              sent_q;
	logic [PORT_W-1:0] out_port_q;
	logic [DATA_W-1:0] flit_out_q;
	logic [PORT_W-1:0] credit_port_q;
	logic              dropped_q;

	logic advance;

	// The item in the input register is processed whenever the result register has room.
	assign advance     = valid_s1 && (!res_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;

	// Configuration writes must arrive only while the router is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			routing_q  <= '0;
			connect_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OWN_ADDR: own_addr_q <= cfg_data[ADDR_W-1:0];
				CFG_ROUTING:  routing_q  <= cfg_data[RBITS_W-1:0];
				CFG_CONNECT:  connect_q  <= cfg_data[CONN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			mode_s1      <= items.mode;
			port_s1      <= items.port;
			slot_s1.data <= items.flit_data;
			slot_s1.kind <= items.flit_kind;
			slot_s1.dest <= items.dest_address;
		end
	end

	// One pass over the state for the item in the input register. On a tick the inputs
	// are tried in order N, E, W, S, L; a route taken by an earlier input occupies its
	// output grant before the later inputs compute theirs, and the first input able to
	// move a flit ends the search.
	always_comb begin : update_pass
		logic              found;
		logic [PORT_W-1:0] r;
		slot_t             f;
		found         = 1'b0;
		r             = REQ_IDLE;
		f             = slot_s1;
		count_n       = count_q;
		req_n         = req_q;
		grant_n       = grant_q;
		cred_n        = cred_q;
		push          = '0;
		pop           = '0;
		sent_n        = 1'b0;
		out_port_n    = '0;
		flit_out_n    = '0;
		credit_port_n = '0;
		dropped_n     = 1'b0;
		case (mode_s1)
			MODE_FLIT: begin
				if (port_s1 < PORT_W'(NPORTS)) begin
					if (count_q[port_s1] == CNT_W'(FIFO_DEPTH)) begin
						dropped_n = 1'b1;
					end else begin
						push[port_s1]    = 1'b1;
						count_n[port_s1] = count_q[port_s1] + 1'b1;
					end
				end
			end
			MODE_CREDIT: begin
				if (port_s1 < PORT_W'(NMESH)) begin
					if (cred_q[port_s1[1:0]] < CRED_W'(MAX_CREDITS))
						cred_n[port_s1[1:0]] = cred_q[port_s1[1:0]] + 1'b1;
				end
			end
			MODE_TICK: begin
				for (int p = 0; p < NPORTS; p++) begin
					if (!found && count_q[p] != '0) begin
						f = fifo_q[p][0];
						r = req_q[p];
						if (r == REQ_IDLE && f.kind == KIND_HEADER) begin
							r = lbdr_route(f.dest, own_addr_q, routing_q, connect_q, grant_n);
							if (r != REQ_IDLE)
								grant_n[r] = 1'b1;
							req_n[p] = r;
						end
						if (r != REQ_IDLE && (r == PORT_L || cred_n[r[1:0]] != '0)) begin
							found = 1'b1;
							if (r != PORT_L)
								cred_n[r[1:0]] = cred_n[r[1:0]] - 1'b1;
							// A tail closes the worm: free the output and idle the input.
							if (f.kind == KIND_TAIL) begin
								grant_n[r] = 1'b0;
								req_n[p]   = REQ_IDLE;
							end
							pop[p]        = 1'b1;
							count_n[p]    = count_q[p] - 1'b1;
							sent_n        = 1'b1;
							out_port_n    = r;
							flit_out_n    = f.data;
							credit_port_n = PORT_W'(p);
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_q <= '0;
			for (int p = 0; p < NPORTS; p++) begin
				count_q[p] <= '0;
				req_q[p]   <= REQ_IDLE;
			end
			for (int m = 0; m < NMESH; m++)
				cred_q[m] <= '0;
		end else if (advance) begin
			grant_q <= grant_n;
			count_q <= count_n;
			req_q   <= req_n;
			cred_q  <= cred_n;
		end
	end

	// FIFO slots: written at the fill position, shifted towards entry 0 on a pop.
	// An arrival and a pop never fall on the same item.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int p = 0; p < NPORTS; p++) begin
				if (push[p]) begin
					fifo_q[p][count_q[p][IDX_W-1:0]] <= slot_s1;
				end else if (pop[p]) begin
					for (int i = 0; i < FIFO_DEPTH - 1; i++)
						fifo_q[p][i] <= fifo_q[p][i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sent_q        <= sent_n;
			out_port_q    <= out_port_n;
			flit_out_q    <= flit_out_n;
			credit_port_q <= credit_port_n;
			dropped_q     <= dropped_n;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.sent        = sent_q;
	assign results.out_port    = out_port_q;
	assign results.flit_out    = flit_out_q;
	assign results.credit_port = credit_port_q;
	assign results.dropped     = dropped_q;

endmodule

`default_nettype wire

[rtl/mnr_checker.sv]
// Port-level checks for the mesh router, attached to the top level by a bind.
// Depends on mnr_pkg for widths and port codes.
`default_nettype none

module mnr_checker import mnr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              r_valid,
	input logic              r_ready,
	input logic              r_sent,
	input logic [PORT_W-1:0] r_out_port,
	input logic [DATA_W-1:0] r_flit_out,
	input logic [PORT_W-1:0] r_credit_port,
	input logic              r_dropped
);

	// A dropped arrival never coincides with a forwarded flit.
	a_drop_not_sent: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_dropped |-> !r_sent)
		else $error("dropped and sent in one result");

	// Without a forwarded flit the forwarding fields are zero.
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_sent |-> r_out_port == '0 && r_flit_out == '0 && r_credit_port == '0)
		else $error("forwarding fields set without a sent flit");

	// A forwarded flit names real ports on both sides.
	a_sent_ports: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_sent |-> (r_out_port == PORT_N || r_out_port == PORT_E
			|| r_out_port == PORT_WEST || r_out_port == PORT_S || r_out_port == PORT_L)
			&& (r_credit_port == PORT_N || r_credit_port == PORT_E
			|| r_credit_port == PORT_WEST || r_credit_port == PORT_S
			|| r_credit_port == PORT_L))
		else $error("sent flit with an invalid port");

	// A result that is not taken stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_sent) && $stable(r_out_port)
			&& $stable(r_flit_out) && $stable(r_credit_port) && $stable(r_dropped))
		else $error("stalled result changed");

endmodule

bind mesh_noc_router_lbdr mnr_checker u_mnr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.r_valid       (results.valid),
	.r_ready       (results.ready),
	.r_sent        (results.sent),
	.r_out_port    (results.out_port),
	.r_flit_out    (results.flit_out),
	.r_credit_port (results.credit_port),
	.r_dropped     (results.dropped)
);

`default_nettype wire

[tb/mesh_noc_router_lbdr_tb.sv]
// Self-checking testbench for the five-port LBDR mesh router: directed cases, random packet
// traffic under several register settings, output back-pressure and stuck-input behaviour.
// Depends on mnr_pkg, the channel interfaces in mnr_if.sv and the mesh_noc_router_lbdr RTL.
module mesh_noc_router_lbdr_tb;
	import mnr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 3;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASE_ITEMS   = 350;
	localparam int EXTREME_ITEMS = 100;
	localparam int STALL_ITEMS   = 40;
	localparam int FLUSH_GUARD   = 300;

	// Codes the package leaves unnamed because the block ignores them.
	localparam logic [MODE_W-1:0]    MODE_UNUSED   = 2'd3;
	localparam logic [KIND_W-1:0]    KIND_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
	localparam logic [PORT_W-1:0]    PORT_MAX_CODE = '1;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [PORT_W-1:0] port;
		logic [DATA_W-1:0] data;
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] dest;
	} router_item_t;

	typedef struct {
		logic              sent;
		logic [PORT_W-1:0] out_port;
		logic [DATA_W-1:0] flit;
		logic [PORT_W-1:0] credit_port;
		logic              dropped;
	} router_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mnr_in_if  items_ch ();
	mnr_out_if results_ch ();

	mesh_noc_router_lbdr dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_ch),
		.results   (results_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the router: FIFOs, held routes, grants, credits and registers.
	slot_t             fifo_mem [NPORTS][FIFO_DEPTH];
	int                fifo_rd [NPORTS];
	int                fifo_fill [NPORTS];
	logic [PORT_W-1:0] held_route [NPORTS];
	logic [NPORTS-1:0] grant_mask;
	int                credit_cnt [NMESH];
	logic [ADDR_W-1:0]  cfg_own;
	logic [RBITS_W-1:0] cfg_turns;
	logic [CONN_W-1:0]  cfg_links;

	// Packet generator state per input port.
	bit gen_in_packet [NPORTS];
	int gen_body_left [NPORTS];

	router_result_t predicted_results [$];
	int             mismatch_count;
	int             src_idle_pct;
	int             sink_idle_pct;
	logic           sink_hold;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// LBDR choice in the fixed order N, E, W, S, then local. Returns REQ_IDLE when no
	// permitted, connected and free output exists.
	function automatic logic [PORT_W-1:0] pick_output(input logic [ADDR_W-1:0] dest,
			input logic [NPORTS-1:0] busy);
		int dx, dy, cx, cy;
		bit go_n, go_e, go_w, go_s;
		logic [PORT_W-1:0] choice;
		dx = int'(dest) % MESH_SIZE;
		dy = int'(dest) / MESH_SIZE;
		cx = int'(cfg_own) % MESH_SIZE;
		cy = int'(cfg_own) / MESH_SIZE;
		go_n = dy < cy;
		go_e = cx < dx;
		go_w = dx < cx;
		go_s = cy < dy;
		choice = REQ_IDLE;
		if (((go_n && !go_e && !go_w) || (go_n && go_e && cfg_turns[0])
				|| (go_n && go_w && cfg_turns[1])) && cfg_links[0] && !busy[PORT_N])
			choice = PORT_N;
		else if (((go_e && !go_n && !go_s) || (go_e && go_n && cfg_turns[2])
				|| (go_e && go_s && cfg_turns[3])) && cfg_links[1] && !busy[PORT_E])
			choice = PORT_E;
		else if (((go_w && !go_n && !go_s) || (go_w && go_n && cfg_turns[4])
				|| (go_w && go_s && cfg_turns[5])) && cfg_links[2] && !busy[PORT_WEST])
			choice = PORT_WEST;
		else if (((go_s && !go_e && !go_w) || (go_s && go_e && cfg_turns[6])
				|| (go_s && go_w && cfg_turns[7])) && cfg_links[3] && !busy[PORT_S])
			choice = PORT_S;
		else if (!go_n && !go_e && !go_w && !go_s && !busy[PORT_L])
			choice = PORT_L;
		return choice;
	endfunction

	// Applies one accepted item to the shadow state and gives the result it must cause.
	function automatic router_result_t router_step(input router_item_t it);
		router_result_t r;
		int p;
		slot_t head;
		logic [PORT_W-1:0] req;
		bit done;
		r = '{default: '0};
		done = 0;
		case (it.mode)
			MODE_FLIT: begin
				if (it.port < NPORTS) begin
					p = int'(it.port);
					if (fifo_fill[p] >= FIFO_DEPTH) begin
						r.dropped = 1'b1;
					end else begin
						fifo_mem[p][(fifo_rd[p] + fifo_fill[p]) % FIFO_DEPTH] =
							'{data: it.data, kind: it.kind, dest: it.dest};
						fifo_fill[p]++;
					end
				end
			end
			MODE_CREDIT: begin
				if (it.port < NMESH && credit_cnt[it.port] < MAX_CREDITS)
					credit_cnt[it.port]++;
			end
			MODE_TICK: begin
				for (p = 0; p < NPORTS && !done; p++) begin
					if (fifo_fill[p] != 0) begin
						head = fifo_mem[p][fifo_rd[p]];
						// A route is only looked up while the input holds none.
						if (held_route[p] == REQ_IDLE && head.kind == KIND_HEADER) begin
							held_route[p] = pick_output(head.dest, grant_mask);
							if (held_route[p] != REQ_IDLE)
								grant_mask[held_route[p]] = 1'b1;
						end
						req = held_route[p];
						if (req != REQ_IDLE && (req == PORT_L || credit_cnt[req] != 0)) begin
							if (req != PORT_L)
								credit_cnt[req]--;
							if (head.kind == KIND_TAIL) begin
								grant_mask[req] = 1'b0;
								held_route[p] = REQ_IDLE;
							end
							fifo_rd[p] = (fifo_rd[p] + 1) % FIFO_DEPTH;
							fifo_fill[p]--;
							r.sent = 1'b1;
							r.out_port = req;
							r.flit = head.data;
							r.credit_port = PORT_W'(p);
							done = 1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic router_item_t tick_item();
		router_item_t it;
		it.mode = MODE_TICK;
		it.port = PORT_W'($urandom);
		it.data = $urandom;
		it.kind = KIND_W'($urandom);
		it.dest = ADDR_W'($urandom);
		return it;
	endfunction

	function automatic router_item_t credit_item(input logic [PORT_W-1:0] port);
		router_item_t it;
		it = tick_item();
		it.mode = MODE_CREDIT;
		it.port = port;
		return it;
	endfunction

	function automatic router_item_t flit_item(input logic [PORT_W-1:0] port,
			input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] dest,
			input logic [DATA_W-1:0] data);
		router_item_t it;
		it.mode = MODE_FLIT;
		it.port = port;
		it.kind = kind;
		it.dest = dest;
		it.data = data;
		return it;
	endfunction

	// Mostly well-formed packets per input, headers only to reachable destinations, so that
	// no input is left with a flit it can never send. Drops are only provoked mid-packet.
	function automatic router_item_t make_traffic_item();
		router_item_t it;
		int roll;
		int p;
		logic [ADDR_W-1:0] d;
		it = tick_item();
		roll = $urandom_range(99);
		if (roll < 4) begin
			it.mode = MODE_UNUSED;
		end else if (roll < 7) begin
			it = flit_item(PORT_W'($urandom_range(PORT_MAX_CODE, NPORTS)), KIND_W'($urandom),
				ADDR_W'($urandom), $urandom);
		end else if (roll < 22) begin
			if ($urandom_range(7) == 0)
				it = credit_item(PORT_W'($urandom_range(PORT_MAX_CODE, PORT_L)));
			else
				it = credit_item(PORT_W'($urandom_range(NMESH - 1, 0)));
		end else if (roll < 60) begin
			p = $urandom_range(NPORTS - 1, 0);
			if (!gen_in_packet[p]) begin
				if (fifo_fill[p] < FIFO_DEPTH) begin
					d = ADDR_W'($urandom);
					for (int t = 0; t < 8 && pick_output(d, '0) == REQ_IDLE; t++)
						d = ADDR_W'($urandom);
					if (pick_output(d, '0) == REQ_IDLE)
						d = cfg_own;
					it = flit_item(PORT_W'(p), KIND_HEADER, d, $urandom);
					gen_in_packet[p] = 1;
					gen_body_left[p] = $urandom_range(3, 0);
				end
			end else if (fifo_fill[p] < FIFO_DEPTH || $urandom_range(3) == 0) begin
				if (gen_body_left[p] == 0) begin
					it = flit_item(PORT_W'(p), KIND_TAIL, ADDR_W'($urandom), $urandom);
					gen_in_packet[p] = 0;
				end else begin
					it = flit_item(PORT_W'(p), ($urandom_range(7) == 0) ? KIND_UNUSED : KIND_BODY,
						ADDR_W'($urandom), $urandom);
					gen_body_left[p]--;
				end
			end
		end
		return it;
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Offers one item, with random gaps beforehand, and records its result once accepted.
	// Valid is left high afterwards so that back-to-back items need no second assignment.
	task automatic send_item(input router_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid        <= 1'b1;
		items_ch.mode         <= it.mode;
		items_ch.port         <= it.port;
		items_ch.flit_data    <= it.data;
		items_ch.flit_kind    <= it.kind;
		items_ch.dest_address <= it.dest;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		predicted_results.push_back(router_step(it));
	endtask

	// Stops offering, waits for every awaited result and lets the pipeline empty.
	task automatic settle_block();
		items_ch.valid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers, plus the unused index, with noise in the unused bits.
	task automatic write_registers(input logic [ADDR_W-1:0] own,
			input logic [RBITS_W-1:0] turns, input logic [CONN_W-1:0] links);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[ADDR_W-1:0] = own;
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_OWN_ADDR;
		cfg_data  <= word;
		@(posedge clk);
		cfg_own = own;
		cfg_index <= CFG_ROUTING;
		cfg_data  <= turns;
		@(posedge clk);
		cfg_turns = turns;
		word = CFG_DATA_W'($urandom);
		word[CONN_W-1:0] = links;
		cfg_index <= CFG_CONNECT;
		cfg_data  <= word;
		@(posedge clk);
		cfg_links = links;
		cfg_index <= CFG_SPARE;
		cfg_data  <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Closes open packets and ticks until the FIFOs are empty, so that no queued header
	// becomes unroutable under the next register setting.
	task automatic flush_traffic();
		bit queued;
		for (int p = 0; p < NPORTS; p++) begin
			if (gen_in_packet[p]) begin
				send_item(flit_item(PORT_W'(p), KIND_TAIL, ADDR_W'($urandom), $urandom));
				gen_in_packet[p] = 0;
			end
		end
		for (int g = 0; g < FLUSH_GUARD; g++) begin
			queued = 0;
			for (int p = 0; p < NPORTS; p++)
				if (fifo_fill[p] != 0)
					queued = 1;
			if (!queued)
				break;
			if (g % 3 == 0)
				send_item(credit_item(PORT_W'((g / 3) % NMESH)));
			else
				send_item(tick_item());
		end
	endtask

	task automatic test_directed_cases();
		router_item_t unused_it;
		src_idle_pct = 0;
		sink_idle_pct <= 0;
		write_registers(ADDR_W'(5), '1, '1);
		send_item(tick_item());                        // empty router
		send_item(credit_item(PORT_N));
		send_item(credit_item(PORT_E));
		send_item(credit_item(PORT_WEST));
		send_item(credit_item(PORT_S));
		repeat (3) send_item(credit_item(PORT_S));     // south saturates
		send_item(credit_item(PORT_L));                // local takes no credit
		send_item(credit_item(PORT_MAX_CODE));         // out-of-range credit port
		// An item with the unused mode changes nothing.
		unused_it = flit_item(PORT_N, KIND_HEADER, '0, '0);
		unused_it.mode = MODE_UNUSED;
		send_item(unused_it);
		send_item(flit_item(PORT_MAX_CODE, KIND_HEADER, '1, '1));
		// North packet; the second header finds a route already held and keeps it.
		send_item(flit_item(PORT_N, KIND_HEADER, ADDR_W'(1), '1));
		send_item(flit_item(PORT_N, KIND_HEADER, '1, $urandom));
		send_item(flit_item(PORT_N, KIND_TAIL, '0, $urandom));
		// Local packet with an unused kind in the body; the fourth arrival overflows.
		send_item(flit_item(PORT_L, KIND_HEADER, ADDR_W'(5), '0));
		send_item(flit_item(PORT_L, KIND_UNUSED, '0, $urandom));
		send_item(flit_item(PORT_L, KIND_TAIL, '0, $urandom));
		send_item(flit_item(PORT_L, KIND_HEADER, ADDR_W'(5), $urandom));
		// North runs out of credit after one flit, so local overtakes it.
		repeat (4) send_item(tick_item());
		send_item(credit_item(PORT_N));
		send_item(credit_item(PORT_N));
		repeat (2) send_item(tick_item());
		settle_block();
		// A diagonal destination with no turn allowed and no links gets no route.
		write_registers(ADDR_W'(5), '0, '0);
		send_item(flit_item(PORT_WEST, KIND_HEADER, '0, $urandom));
		send_item(tick_item());
		settle_block();
		write_registers(ADDR_W'(5), '1, '1);
		send_item(tick_item());
		settle_block();
	endtask

	task automatic test_route_traffic();
		for (int phase = 0; phase < 3; phase++) begin
			flush_traffic();
			settle_block();
			case (phase)
				0: begin
					src_idle_pct = 17;
					sink_idle_pct <= 54;
					write_registers(ADDR_W'($urandom), RBITS_W'($urandom), '1);
				end
				1: begin
					src_idle_pct = 54;
					sink_idle_pct <= 17;
					write_registers(ADDR_W'($urandom), '1, CONN_W'($urandom));
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct <= 0;
					write_registers(ADDR_W'($urandom), RBITS_W'($urandom), CONN_W'($urandom));
				end
			endcase
			repeat (PHASE_ITEMS) send_item(make_traffic_item());
		end
	endtask

	// The receiver refuses results for a long stretch while items keep coming, so the
	// router's pipeline fills and it must hold off the sender.
	task automatic test_output_stall();
		src_idle_pct = 0;
		sink_idle_pct <= 0;
		fork
			begin
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
			end
		join_none
		repeat (STALL_ITEMS) send_item(make_traffic_item());
	endtask

	task automatic test_config_extremes();
		src_idle_pct = 17;
		sink_idle_pct <= 54;
		flush_traffic();
		settle_block();
		write_registers('0, '0, '0);
		repeat (EXTREME_ITEMS) send_item(make_traffic_item());
		flush_traffic();
		settle_block();
		write_registers('1, '1, '1);
		repeat (EXTREME_ITEMS) send_item(make_traffic_item());
	endtask

	// A body flit at the head of an idle input blocks it for good; done last for that reason.
	task automatic test_idle_non_header();
		int p;
		flush_traffic();
		p = int'(PORT_L);
		for (int q = 0; q < NPORTS; q++)
			if (fifo_fill[q] == 0 && held_route[q] == REQ_IDLE)
				p = q;
		send_item(flit_item(PORT_W'(p), KIND_BODY, ADDR_W'($urandom), $urandom));
		send_item(tick_item());
		send_item(flit_item(PORT_W'(p), KIND_HEADER, cfg_own, $urandom));
		send_item(tick_item());
	endtask

	// The receiver accepts at random unless a long hold-off is running.
	always @(posedge clk)
		results_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin : result_check
		router_result_t want;
		if (results_ch.valid && results_ch.ready) begin
			if (predicted_results.size() == 0) begin
				$display("%0t ns: result with none awaited, expected nothing, actual sent=%0h",
					$time, results_ch.sent);
				mismatch_count++;
			end else begin
				want = predicted_results.pop_front();
				check_field("sent", DATA_W'(want.sent), DATA_W'(results_ch.sent));
				check_field("out_port", DATA_W'(want.out_port), DATA_W'(results_ch.out_port));
				check_field("flit_out", want.flit, results_ch.flit_out);
				check_field("credit_port", DATA_W'(want.credit_port),
					DATA_W'(results_ch.credit_port));
				check_field("dropped", DATA_W'(want.dropped), DATA_W'(results_ch.dropped));
			end
		end
	end

	// Ends the run when no handshake happens on either channel for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_ch.valid = 1'b0;
		items_ch.mode = '0;
		items_ch.port = '0;
		items_ch.flit_data = '0;
		items_ch.flit_kind = '0;
		items_ch.dest_address = '0;
		results_ch.ready = 1'b0;
		sink_hold = 1'b0;
		mismatch_count = 0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		for (int p = 0; p < NPORTS; p++) begin
			fifo_rd[p] = 0;
			fifo_fill[p] = 0;
			held_route[p] = REQ_IDLE;
			gen_in_packet[p] = 0;
			gen_body_left[p] = 0;
		end
		for (int m = 0; m < NMESH; m++)
			credit_cnt[m] = 0;
		grant_mask = '0;
		cfg_own = '0;
		cfg_turns = '0;
		cfg_links = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_cases();
		test_route_traffic();
		test_output_stall();
		test_config_extremes();
		test_idle_non_header();
		settle_block();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[mesh_noc_router_lbdr.f]
rtl/mnr_pkg.sv
rtl/mnr_if.sv
rtl/mesh_noc_router_lbdr.sv
rtl/mnr_checker.sv
tb/mesh_noc_router_lbdr_tb.sv
